// File: rtl/core/tqm_pkg.sv
`default_nettype none
package tqm_pkg;

   localparam int SLOT_W = 4;
   localparam int TAG_W  = 16;
   localparam int TIME_W = 48;
   localparam int STAT_W = 3;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_CANCELLED = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EXPIRED   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_TICK_DONE = 3'd5;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [SLOT_W-1:0] timer_slot;
      logic [TAG_W-1:0]  timer_tag;
      logic [TIME_W-1:0] expiry_time;
      logic [TIME_W-1:0] repeat_interval;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status_code;
      logic [SLOT_W-1:0] slot_out;
      logic [TAG_W-1:0]  tag_out;
      logic [TIME_W-1:0] fired_expiry;
      logic              earliest_changed;
      logic [TIME_W-1:0] next_deadline;
      logic              next_valid;
      logic              last_item;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAN_CHK,
      ST_SCAN,
      ST_ADD_WR,
      ST_FIRE_GEN,
      ST_REARM
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/tqm_ram.sv
`default_nettype none
module tqm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/timer_queue_manager.sv
// Timer queue: expiry, interval and tag live in single-port-read RAMs, scanned one slot a cycle.
// On tick, each min search is a RAM scan.
// One item at a time: busy is high from acceptance until the last word is driven.
// Each word is on rsp_data for one cycle with rsp_strobe; the receiver cannot stall.
// Synchronous reset clears all valid marks and the tag counter; RAM contents are not cleared.
`default_nettype none
module timer_queue_manager #(
   parameter int TIMER_SLOTS = 16,
   parameter int TIME_BITS   = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tqm_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tqm_pkg::rsp_type      rsp_data
);
   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TIMER_SLOTS);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   tqm_pkg::state_type state_ff, state_in;
   tqm_pkg::req_type   req_ff, req_in;
   tqm_pkg::rsp_type   rsp_ff, rsp_in;
   logic rsp_strobe_ff, rsp_strobe_in;

   logic [tqm_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic fire_mode_ff, fire_mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic any_ff, any_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] fired_ff, fired_in;
   logic [tqm_pkg::TAG_W-1:0] tag_cnt_ff, tag_cnt_in;

   // RAM ports
   logic exp_we, int_we, gen_we;
   logic [IDX_W-1:0] exp_wa, gen_ra;
   logic [TIME_BITS-1:0] exp_wd, exp_rd, int_rd;
   logic [tqm_pkg::TAG_W-1:0] gen_rd;

   // helpers
   logic [IDX_W-1:0] free_idx;
   logic free_any;
   logic scan_done;
   logic [TIME_BITS-1:0] now_t, add_exp;
   logic [TIME_BITS:0] rearm_sum;
   logic cand;
   logic can_hit;
   logic [IDX_W-1:0] req_slot_idx;

   tqm_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_exp_ram (
      .clock(clock), .wr_en(exp_we), .wr_addr(exp_wa), .wr_data(exp_wd),
      .rd_addr(cnt_ff[IDX_W-1:0]), .rd_data(exp_rd)
   );

   tqm_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_int_ram (
      .clock(clock), .wr_en(int_we), .wr_addr(slot_ff),
      .wr_data(TIME_BITS'(req_ff.repeat_interval)),
      .rd_addr(cnt_ff[IDX_W-1:0]), .rd_data(int_rd)
   );

   tqm_ram #(.WIDTH(tqm_pkg::TAG_W), .DEPTH(TIMER_SLOTS)) u_gen_ram (
      .clock(clock), .wr_en(gen_we), .wr_addr(slot_ff), .wr_data(tag_cnt_ff),
      .rd_addr(gen_ra), .rd_data(gen_rd)
   );

   assign busy       = (state_ff != tqm_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign now_t        = TIME_BITS'(req_ff.now_time);
   assign add_exp      = TIME_BITS'(req_ff.expiry_time);
   assign rearm_sum    = {1'b0, now_t} + {1'b0, int_rd};
   assign scan_done    = (cnt_ff == CNT_END) && !rd_vld_ff;
   assign req_slot_idx = IDX_W'(req_data.timer_slot);
   assign can_hit      = (32'(req_data.timer_slot) < TIMER_SLOTS) && valid_ff[req_slot_idx];

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign cand = rd_vld_ff && valid_ff[rd_idx_ff] &&
                 (!fire_mode_ff || (!fired_ff[rd_idx_ff] && (exp_rd <= now_t)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tqm_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.opcode == tqm_pkg::OP_CANCEL && can_hit) begin
                  state_in = tqm_pkg::ST_CAN_CHK;
               end else begin
                  state_in = tqm_pkg::ST_SCAN;
               end
            end
         end
         tqm_pkg::ST_CAN_CHK: state_in = tqm_pkg::ST_SCAN;
         tqm_pkg::ST_SCAN: begin
            if (scan_done) begin
               if (fire_mode_ff) begin
                  state_in = any_ff ? tqm_pkg::ST_FIRE_GEN : tqm_pkg::ST_REARM;
               end else if (stat_ff == tqm_pkg::STAT_ADDED) begin
                  state_in = tqm_pkg::ST_ADD_WR;
               end else begin
                  state_in = tqm_pkg::ST_IDLE;
               end
            end
         end
         tqm_pkg::ST_ADD_WR:   state_in = tqm_pkg::ST_IDLE;
         tqm_pkg::ST_FIRE_GEN: state_in = tqm_pkg::ST_SCAN;
         tqm_pkg::ST_REARM: begin
            if (scan_done) begin
               state_in = tqm_pkg::ST_SCAN;
            end
         end
         default: state_in = tqm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      stat_in       = stat_ff;
      fire_mode_in  = fire_mode_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_in       = best_ff;
      any_in        = any_ff;
      pick_in       = pick_ff;
      slot_in       = slot_ff;
      valid_in      = valid_ff;
      fired_in      = fired_ff;
      tag_cnt_in    = tag_cnt_ff;
      exp_we        = 1'b0;
      exp_wa        = slot_ff;
      exp_wd        = add_exp;
      int_we        = 1'b0;
      gen_we        = 1'b0;
      gen_ra        = pick_ff;

      // shared scan walker: issue one read per cycle, consume it in the next cycle
      if (state_ff == tqm_pkg::ST_SCAN || state_ff == tqm_pkg::ST_REARM) begin
         if (cnt_ff != CNT_END) begin
            cnt_in    = cnt_ff + 1'b1;
            rd_vld_in = 1'b1;
            rd_idx_in = cnt_ff[IDX_W-1:0];
         end
      end

      unique case (state_ff)
         tqm_pkg::ST_IDLE: begin
            gen_ra       = req_slot_idx;
            cnt_in       = '0;
            any_in       = 1'b0;
            fire_mode_in = 1'b0;
            if (start) begin
               req_in = req_data;
               case (req_data.opcode)
                  tqm_pkg::OP_ADD: begin
                     stat_in = free_any ? tqm_pkg::STAT_ADDED : tqm_pkg::STAT_FULL;
                     slot_in = free_idx;
                  end
                  tqm_pkg::OP_CANCEL: stat_in = tqm_pkg::STAT_NOT_FOUND;
                  tqm_pkg::OP_TICK: begin
                     stat_in      = tqm_pkg::STAT_TICK_DONE;
                     fire_mode_in = 1'b1;
                  end
                  default: stat_in = tqm_pkg::STAT_TICK_DONE;
               endcase
            end
         end
         tqm_pkg::ST_CAN_CHK: begin
            if (gen_rd == req_ff.timer_tag) begin
               stat_in = tqm_pkg::STAT_CANCELLED;
               valid_in[IDX_W'(req_ff.timer_slot)] = 1'b0;
            end
         end
         tqm_pkg::ST_SCAN: begin
            if (cand && (!any_ff || exp_rd < best_ff)) begin
               best_in = exp_rd;
               any_in  = 1'b1;
               pick_in = rd_idx_ff;
            end
            if (scan_done && fire_mode_ff && any_ff) begin
               fired_in[pick_ff] = 1'b1;
            end else if (scan_done && !fire_mode_ff && stat_ff != tqm_pkg::STAT_ADDED) begin
               rsp_strobe_in        = 1'b1;
               rsp_in.status_code   = stat_ff;
               rsp_in.next_valid    = any_ff;
               rsp_in.next_deadline = any_ff ? tqm_pkg::TIME_W'(best_ff) : '0;
               rsp_in.last_item     = 1'b1;
               if (stat_ff == tqm_pkg::STAT_CANCELLED ||
                   stat_ff == tqm_pkg::STAT_NOT_FOUND) begin
                  rsp_in.slot_out = req_ff.timer_slot;
                  rsp_in.tag_out  = req_ff.timer_tag;
               end
            end
         end
         tqm_pkg::ST_ADD_WR: begin
            exp_we           = 1'b1;
            int_we           = 1'b1;
            gen_we           = 1'b1;
            valid_in[slot_ff] = 1'b1;
            tag_cnt_in       = tag_cnt_ff + 1'b1;
            rsp_strobe_in    = 1'b1;
            rsp_in.status_code      = tqm_pkg::STAT_ADDED;
            rsp_in.slot_out         = tqm_pkg::SLOT_W'(slot_ff);
            rsp_in.tag_out          = tag_cnt_ff;
            rsp_in.earliest_changed = !any_ff || (add_exp < best_ff);
            rsp_in.next_deadline    = (!any_ff || add_exp < best_ff) ?
                                      tqm_pkg::TIME_W'(add_exp) : tqm_pkg::TIME_W'(best_ff);
            rsp_in.next_valid       = 1'b1;
            rsp_in.last_item        = 1'b1;
         end
         tqm_pkg::ST_FIRE_GEN: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.status_code  = tqm_pkg::STAT_EXPIRED;
            rsp_in.slot_out     = tqm_pkg::SLOT_W'(pick_ff);
            rsp_in.tag_out      = gen_rd;
            rsp_in.fired_expiry = tqm_pkg::TIME_W'(best_ff);
            cnt_in              = '0;
            any_in              = 1'b0;
         end
         tqm_pkg::ST_REARM: begin
            // repeating timers move to now + interval, saturated; one-shots free their slot
            if (rd_vld_ff && fired_ff[rd_idx_ff]) begin
               if (int_rd != '0) begin
                  exp_we = 1'b1;
                  exp_wa = rd_idx_ff;
                  exp_wd = rearm_sum[TIME_BITS] ? TMAX : rearm_sum[TIME_BITS-1:0];
               end else begin
                  valid_in[rd_idx_ff] = 1'b0;
               end
            end
            if (scan_done) begin
               fired_in     = '0;
               fire_mode_in = 1'b0;
               cnt_in       = '0;
               any_in       = 1'b0;
            end
         end
         default: ;
      endcase

      // fresh walk whenever the FSM leaves a state into a scan
      if (state_ff == tqm_pkg::ST_CAN_CHK) begin
         cnt_in = '0;
         any_in = 1'b0;
      end
      if (state_ff == tqm_pkg::ST_SCAN && scan_done && fire_mode_ff && !any_ff) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tqm_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
         fired_ff      <= '0;
         tag_cnt_ff    <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         any_ff        <= 1'b0;
         fire_mode_ff  <= 1'b0;
         stat_ff       <= tqm_pkg::STAT_TICK_DONE;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         valid_ff      <= valid_in;
         fired_ff      <= fired_in;
         tag_cnt_ff    <= tag_cnt_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         any_ff        <= any_in;
         fire_mode_ff  <= fire_mode_in;
         stat_ff       <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      rd_idx_ff <= rd_idx_in;
      best_ff   <= best_in;
      pick_ff   <= pick_in;
      slot_ff   <= slot_in;
   end
endmodule
`default_nettype wire
